>>> hw/rtl/wbs_pkg.sv
// shared types, codes and reset helpers for the weighted backend selector
package wbs_pkg;

    // default sizing
    localparam int DEF_MAX_HOSTS   = 8;
    localparam int DEF_WEIGHT_BITS = 8;

    // register reset values
    localparam logic [63:0] RST_HOST_WEIGHTS = 64'h0101_0101_0101_0101;
    localparam logic [3:0]  RST_HOSTS_IN_USE = 4'd8;
    localparam logic [15:0] RST_RETRY_UNIT   = 16'd5;

    // register indexes (address bits [4:3])
    localparam logic [1:0] REG_HOST_WEIGHTS = 2'd0;
    localparam logic [1:0] REG_HOSTS_IN_USE = 2'd1;
    localparam logic [1:0] REG_RETRY_UNIT   = 2'd2;

    // operation codes
    localparam logic [1:0] OP_SELECT = 2'd0;
    localparam logic [1:0] OP_FAIL   = 2'd1;
    localparam logic [1:0] OP_RELOAD = 2'd2;

    // result kinds
    localparam logic [1:0] RK_SELECTED = 2'd0;
    localparam logic [1:0] RK_OFFLINE  = 2'd1;
    localparam logic [1:0] RK_FAILED   = 2'd2;
    localparam logic [1:0] RK_RELOADED = 2'd3;

    // host health states
    localparam logic [1:0] ST_UNKNOWN      = 2'd0;
    localparam logic [1:0] ST_OK           = 2'd1;
    localparam logic [1:0] ST_FAIL_RESOLVE = 2'd2;
    localparam logic [1:0] ST_FAIL_CONNECT = 2'd3;

    // backoff multipliers
    localparam logic [3:0] RESOLVE_MULT = 4'd10;
    localparam logic [3:0] MAX_DRAW     = 4'd9;

    // credit unit control
    typedef enum logic {
        CU_ADD,
        CU_SUB
    } t_cu_fn;

    typedef struct packed {
        t_cu_fn fn;
        logic   a_is_weight;
    } t_cu_ctrl;

    // weight field of host i, zero past the end of the word
    function automatic logic [63:0] weight_field(input logic [63:0] hw, input int i,
                                                 input int wb);
        logic [63:0] mask;
        mask = (64'd1 << wb) - 64'd1;
        if (i * wb >= 64) begin
            return 64'd0;
        end
        return (hw >> (i * wb)) & mask;
    endfunction

    // largest reset weight among the first n hosts
    function automatic int reset_max(input int n, input int wb);
        int m;
        int w;
        m = 0;
        for (int i = 0; i < n; i++) begin
            w = int'(weight_field(RST_HOST_WEIGHTS, i, wb));
            if (w > m) begin
                m = w;
            end
        end
        return m;
    endfunction

    // least reset weight among the first n hosts
    function automatic int reset_least(input int n, input int wb);
        int m;
        int w;
        m = reset_max(n, wb);
        for (int i = 0; i < n; i++) begin
            w = int'(weight_field(RST_HOST_WEIGHTS, i, wb));
            if (w < m) begin
                m = w;
            end
        end
        return m;
    endfunction

    // first host holding the largest reset weight
    function automatic int reset_cursor(input int n, input int wb);
        int c;
        int m;
        int w;
        c = 0;
        m = int'(weight_field(RST_HOST_WEIGHTS, 0, wb));
        for (int i = 1; i < n; i++) begin
            w = int'(weight_field(RST_HOST_WEIGHTS, i, wb));
            if (w > m) begin
                m = w;
                c = i;
            end
        end
        return c;
    endfunction

    // reset credit of host i
    function automatic int reset_credit(input int i, input int n, input int wb);
        if (i >= n) begin
            return 0;
        end
        return int'(weight_field(RST_HOST_WEIGHTS, i, wb)) - (reset_max(n, wb) >> 1);
    endfunction

endpackage

>>> hw/rtl/wbs_credit_unit.sv
// shared credit adder used by the walk, the wrap refill and the reload
module wbs_credit_unit #(
    parameter int WEIGHT_BITS = wbs_pkg::DEF_WEIGHT_BITS,
    parameter int CREDIT_BITS = wbs_pkg::DEF_WEIGHT_BITS + 3
) (
    input  wbs_pkg::t_cu_ctrl              i_ctrl,
    input  logic signed [CREDIT_BITS-1:0]  i_credit,
    input  logic        [WEIGHT_BITS-1:0]  i_weight,
    input  logic        [WEIGHT_BITS-1:0]  i_operand,
    output logic signed [CREDIT_BITS-1:0]  o_sum,
    output logic                           o_credit_pos
);

    logic signed [CREDIT_BITS-1:0] a_val;
    logic signed [CREDIT_BITS-1:0] b_val;

    // operand selection
    assign a_val = i_ctrl.a_is_weight
                 ? $signed({{(CREDIT_BITS-WEIGHT_BITS){1'b0}}, i_weight})
                 : i_credit;
    assign b_val = $signed({{(CREDIT_BITS-WEIGHT_BITS){1'b0}}, i_operand});

    // add or subtract
    always_comb begin
        case (i_ctrl.fn)
            wbs_pkg::CU_ADD: o_sum = a_val + b_val;
            wbs_pkg::CU_SUB: o_sum = a_val - b_val;
            default:         o_sum = a_val - b_val;
        endcase
    end

    // credit strictly positive
    assign o_credit_pos = !i_credit[CREDIT_BITS-1] && (i_credit != '0);

endmodule

>>> hw/rtl/weighted_backend_selector.sv
// weighted round-robin host selector, top level
//
// Input channel (i_in_valid / o_in_stall) carries one op word: select, report
// failure or reload. Output channel (o_out_valid / i_out_stall) returns one
// word per op: result kind and chosen host. Op code 3 is taken and dropped.
// Configuration goes through the APB-style port, 64-bit registers at 8*i.
// One op is worked at a time; o_in_stall is high until its word is queued.
// Steps from accept to o_out_valid:
//   failure report: multiply, saturating add, output
//   reload: scan of the n hosts in use, then load of all MAX_HOSTS credits
//   select: walk and refill steps; the walk visits one host per cycle and
//   each wrap visits the n hosts one per cycle, refilling spent credits, with
//   at most two walks and two refills
// All credit arithmetic goes through one shared adder indexed by the sequencer.
// After reset the registers hold their defaults and the credits, least weight
// and cursor already hold the reloaded values, so ops are taken at once.
// A finished word waits in a stage of its own while the receiver stalls and
// the output register stays unchanged; the next op is taken when the output
// register can be freed.
module weighted_backend_selector #(
    parameter int MAX_HOSTS   = wbs_pkg::DEF_MAX_HOSTS,
    parameter int WEIGHT_BITS = wbs_pkg::DEF_WEIGHT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_now,
    input  logic [2:0]  i_host,
    input  logic        i_fail_kind,
    input  logic [3:0]  i_random_draw,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_chosen_host,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int WB = WEIGHT_BITS;
    localparam int CW = WEIGHT_BITS + 3;
    localparam int IW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
    localparam int NW = $clog2(MAX_HOSTS + 1);
    localparam int INIT_N = (MAX_HOSTS < int'(wbs_pkg::RST_HOSTS_IN_USE))
                          ? MAX_HOSTS : int'(wbs_pkg::RST_HOSTS_IN_USE);
    localparam logic [WB-1:0] INIT_LEAST  = WB'(wbs_pkg::reset_least(INIT_N, WB));
    localparam logic [IW-1:0] INIT_CURSOR = IW'(wbs_pkg::reset_cursor(INIT_N, WB));

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_WRAP,
        S_RL_SCAN,
        S_RL_LOAD,
        S_FAIL_MUL,
        S_FAIL_ADD,
        S_DONE
    } t_state;

    // configuration registers
    logic [63:0] r_host_weights;
    logic [3:0]  r_hosts_in_use;
    logic [15:0] r_retry_unit;

    // selector state
    logic signed [CW-1:0] r_credit [MAX_HOSTS];
    logic [WB-1:0]        r_least;
    logic [IW-1:0]        r_cursor;
    logic [1:0]           r_hstate [MAX_HOSTS];
    logic [31:0]          r_retry  [MAX_HOSTS];

    // sequencer
    t_state        r_state;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_bound;
    logic          r_wrapped;
    logic          r_any_ok;
    logic [WB-1:0] r_maxw;
    logic [WB-1:0] r_minw;
    logic [IW-1:0] r_arg;
    logic [19:0]   r_prod;

    // latched op word
    logic [31:0] r_now;
    logic [2:0]  r_host;
    logic        r_kind;
    logic [3:0]  r_draw;

    // pending and output result
    logic [1:0] r_res_kind;
    logic [2:0] r_res_host;
    logic       r_out_valid;
    logic [1:0] r_out_kind;
    logic [2:0] r_out_host;

    logic [NW-1:0]        act_n;
    logic [WB-1:0]        w_arr [MAX_HOSTS];
    logic [WB-1:0]        cur_w;
    logic [NW-1:0]        idx_p1;
    logic                 idx_last;
    logic                 idx_all_last;
    logic [IW-1:0]        idx_succ;
    logic                 idx_in_use;
    logic [IW-1:0]        cur_clamp;
    logic                 promotable;
    logic                 pick;
    logic                 any_ok;
    logic                 host_ok;
    logic [3:0]           mult;
    logic [32:0]          retry_sum;
    logic [31:0]          retry_sat;
    logic                 in_fire;
    logic                 out_free;
    logic                 cfg_wr;
    wbs_pkg::t_cu_ctrl    cu_ctrl;
    logic [WB-1:0]        cu_weight;
    logic [WB-1:0]        cu_operand;
    logic signed [CW-1:0] cu_sum;
    logic                 cu_pos;

    // configuration write and read back
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_weights <= wbs_pkg::RST_HOST_WEIGHTS;
            r_hosts_in_use <= wbs_pkg::RST_HOSTS_IN_USE;
            r_retry_unit   <= wbs_pkg::RST_RETRY_UNIT;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                wbs_pkg::REG_HOST_WEIGHTS: r_host_weights <= pwdata;
                wbs_pkg::REG_HOSTS_IN_USE: r_hosts_in_use <= pwdata[3:0];
                wbs_pkg::REG_RETRY_UNIT:   r_retry_unit   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            wbs_pkg::REG_HOST_WEIGHTS: prdata = r_host_weights;
            wbs_pkg::REG_HOSTS_IN_USE: prdata = {60'd0, r_hosts_in_use};
            wbs_pkg::REG_RETRY_UNIT:   prdata = {48'd0, r_retry_unit};
            default:                   prdata = 64'd0;
        endcase
    end

    // hosts taking part, clamped to 1..MAX_HOSTS
    always_comb begin
        if (r_hosts_in_use == 4'd0) begin
            act_n = NW'(1);
        end else if ({1'b0, r_hosts_in_use} > 5'(MAX_HOSTS)) begin
            act_n = NW'(MAX_HOSTS);
        end else begin
            act_n = NW'(r_hosts_in_use);
        end
    end

    // unpacked weights
    for (genvar g = 0; g < MAX_HOSTS; g++) begin : g_weight
        assign w_arr[g] = WB'(wbs_pkg::weight_field(r_host_weights, g, WB));
    end

    assign cur_w = w_arr[r_idx];

    // index stepping
    assign idx_p1       = NW'(r_idx) + NW'(1);
    assign idx_last     = (idx_p1 == act_n);
    assign idx_all_last = (idx_p1 == NW'(MAX_HOSTS));
    assign idx_succ     = idx_last ? '0 : IW'(idx_p1);
    assign idx_in_use   = (NW'(r_idx) < act_n);
    assign cur_clamp    = (NW'(r_cursor) >= act_n) ? '0 : r_cursor;

    // pick test for the host under the walk
    assign promotable = (r_hstate[r_idx] == wbs_pkg::ST_OK)
                     || (r_hstate[r_idx] == wbs_pkg::ST_UNKNOWN)
                     || (r_now >= r_retry[r_idx]);
    assign pick   = cu_pos && promotable;
    assign any_ok = r_any_ok || (r_hstate[r_idx] == wbs_pkg::ST_OK);

    // failure backoff
    assign host_ok   = (5'(r_host) < 5'(MAX_HOSTS));
    assign mult      = !r_kind ? wbs_pkg::RESOLVE_MULT
                     : (r_draw > wbs_pkg::MAX_DRAW) ? (wbs_pkg::MAX_DRAW + 4'd1)
                     : (r_draw + 4'd1);
    assign retry_sum = {1'b0, r_now} + 33'(r_prod);
    assign retry_sat = retry_sum[32] ? 32'hFFFF_FFFF : retry_sum[31:0];

    // handshakes
    assign in_fire    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // shared credit unit operands
    always_comb begin
        cu_ctrl.fn          = wbs_pkg::CU_SUB;
        cu_ctrl.a_is_weight = 1'b0;
        cu_weight           = cur_w;
        cu_operand          = r_least;
        case (r_state)
            S_WRAP: begin
                cu_ctrl.fn = wbs_pkg::CU_ADD;
                cu_operand = cur_w;
            end
            S_RL_LOAD: begin
                cu_ctrl.a_is_weight = 1'b1;
                cu_weight           = idx_in_use ? cur_w : '0;
                cu_operand          = idx_in_use ? (r_maxw >> 1) : '0;
            end
            default: ;
        endcase
    end

    wbs_credit_unit #(
        .WEIGHT_BITS (WB),
        .CREDIT_BITS (CW)
    ) u_credit_unit (
        .i_ctrl       (cu_ctrl),
        .i_credit     (r_credit[r_idx]),
        .i_weight     (cu_weight),
        .i_operand    (cu_operand),
        .o_sum        (cu_sum),
        .o_credit_pos (cu_pos)
    );

    // sequencer, selector state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_least     <= INIT_LEAST;
            r_cursor    <= INIT_CURSOR;
            for (int i = 0; i < MAX_HOSTS; i++) begin
                r_credit[i] <= CW'(wbs_pkg::reset_credit(i, INIT_N, WB));
                r_hstate[i] <= wbs_pkg::ST_UNKNOWN;
                r_retry[i]  <= 32'd0;
            end
        end else begin
            // output register: load a finished word or drop a taken one
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= r_res_kind;
                r_out_host  <= r_res_host;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_now  <= i_now;
                        r_host <= i_host;
                        r_kind <= i_fail_kind;
                        r_draw <= i_random_draw;
                        case (i_op)
                            wbs_pkg::OP_SELECT: begin
                                r_cursor  <= cur_clamp;
                                r_bound   <= cur_clamp;
                                r_idx     <= cur_clamp;
                                r_wrapped <= 1'b0;
                                r_state   <= S_WALK;
                            end
                            wbs_pkg::OP_FAIL: begin
                                r_state <= S_FAIL_MUL;
                            end
                            wbs_pkg::OP_RELOAD: begin
                                r_idx  <= '0;
                                r_maxw <= '0;
                                r_minw <= '1;
                                r_arg  <= '0;
                                for (int i = 0; i < MAX_HOSTS; i++) begin
                                    r_hstate[i] <= wbs_pkg::ST_UNKNOWN;
                                    r_retry[i]  <= 32'd0;
                                end
                                r_state <= S_RL_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                // one host per cycle from the cursor
                S_WALK: begin
                    if (pick) begin
                        r_credit[r_idx] <= cu_sum;
                        r_hstate[r_idx] <= wbs_pkg::ST_OK;
                        r_cursor        <= idx_succ;
                        r_res_kind      <= wbs_pkg::RK_SELECTED;
                        r_res_host      <= 3'(r_idx);
                        r_state         <= S_DONE;
                    end else if (idx_succ == r_bound) begin
                        r_idx    <= '0;
                        r_any_ok <= 1'b0;
                        r_state  <= S_WRAP;
                    end else begin
                        r_idx <= idx_succ;
                    end
                end
                // refill spent credits and look for a healthy host
                S_WRAP: begin
                    if (!cu_pos) begin
                        r_credit[r_idx] <= cu_sum;
                    end
                    if (idx_last) begin
                        if (!any_ok || r_wrapped) begin
                            r_res_kind <= wbs_pkg::RK_OFFLINE;
                            r_res_host <= 3'd0;
                            r_state    <= S_DONE;
                        end else begin
                            r_wrapped <= 1'b1;
                            r_idx     <= r_bound;
                            r_state   <= S_WALK;
                        end
                    end else begin
                        r_any_ok <= any_ok;
                        r_idx    <= idx_succ;
                    end
                end
                // find largest, least and first largest weight
                S_RL_SCAN: begin
                    if (cur_w > r_maxw) begin
                        r_maxw <= cur_w;
                        r_arg  <= r_idx;
                    end
                    if (cur_w < r_minw) begin
                        r_minw <= cur_w;
                    end
                    if (idx_last) begin
                        r_idx   <= '0;
                        r_state <= S_RL_LOAD;
                    end else begin
                        r_idx <= idx_succ;
                    end
                end
                // load every credit, zero past the hosts in use
                S_RL_LOAD: begin
                    r_credit[r_idx] <= cu_sum;
                    if (idx_all_last) begin
                        r_least    <= r_minw;
                        r_cursor   <= r_arg;
                        r_res_kind <= wbs_pkg::RK_RELOADED;
                        r_res_host <= 3'd0;
                        r_state    <= S_DONE;
                    end else begin
                        r_idx <= IW'(idx_p1);
                    end
                end
                S_FAIL_MUL: begin
                    r_prod  <= 20'(mult) * 20'(r_retry_unit);
                    r_state <= S_FAIL_ADD;
                end
                S_FAIL_ADD: begin
                    if (host_ok) begin
                        r_hstate[IW'(r_host)] <= r_kind ? wbs_pkg::ST_FAIL_CONNECT
                                                        : wbs_pkg::ST_FAIL_RESOLVE;
                        r_retry[IW'(r_host)]  <= retry_sat;
                    end
                    r_res_kind <= wbs_pkg::RK_FAILED;
                    r_res_host <= 3'd0;
                    r_state    <= S_DONE;
                end
                // hand the word to the output register
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_chosen_host = r_out_host;

    // walk and refill stay inside the hosts in use
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_WRAP) |-> (NW'(r_idx) < act_n))
        else $error("walk index beyond hosts in use");

    // a pick always ends the op as a selection
    a_pick_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && pick) |=>
        (r_state == S_DONE && r_res_kind == wbs_pkg::RK_SELECTED))
        else $error("pick did not complete as selection");

    // the second refill without a pick reports all offline
    a_second_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRAP && idx_last && r_wrapped) |=>
        (r_state == S_DONE && r_res_kind == wbs_pkg::RK_OFFLINE))
        else $error("second wrap did not report offline");

    // a new output word comes only from the done stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("output word raised outside done stage");

endmodule
